// ===== hdl/frc_pkg.sv =====
// ----------------------------------------------------------------------------
// frc_pkg
// shared widths, command codes and status codes of the range counter
// ----------------------------------------------------------------------------
package frc_pkg;

   localparam int CMD_W    = 2;
   localparam int FIELD_W  = 11;
   localparam int COUNT_W  = 20;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_INC   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [COUNT_W-1:0] TOTAL_MAX = '1;

endpackage

// ===== hdl/frc_if.sv =====
// ----------------------------------------------------------------------------
// frc_req_if / frc_rsp_if
// valid/ready channels carrying command beats in and result beats out
// ----------------------------------------------------------------------------
interface frc_req_if
   import frc_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [FIELD_W-1:0] position;
   logic [FIELD_W-1:0] left;
   logic [FIELD_W-1:0] right;

   modport source (output valid, command, position, left, right, input ready);
   modport sink   (input valid, command, position, left, right, output ready);
endinterface

interface frc_rsp_if
   import frc_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  count;
   logic [STATUS_W-1:0] status;

   modport source (output valid, count, status, input ready);
   modport sink   (input valid, count, status, output ready);
endinterface

// ===== hdl/frc_ram.sv =====
// ----------------------------------------------------------------------------
// frc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module frc_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/fenwick_range_counter.sv =====
// ----------------------------------------------------------------------------
// fenwick_range_counter
// binary indexed tree of occurrence counts: increment, range count, clear
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | command, position, left, right
//  rsp     | out | count, status (one beat per request beat)
//
//  increment: each node on the upward walk is read, then written back plus one
//  query: one ram read per node of prefix(right) and, when left-1 is non-zero,
//  one ram read per node of prefix(left-1)
//  clear: one ram row zeroed per cycle
//  after reset the same sweep runs before req.ready rises
//  req.ready is high only while the sequencer is idle; a result beat waits in
//  the output register, the sequencer stalls only if a second result is due
// ----------------------------------------------------------------------------
module fenwick_range_counter
   import frc_pkg::*;
#(
   parameter int POSITIONS = 1024
) (
   input  logic      clock,
   input  logic      reset,
   frc_req_if.sink   req,
   frc_rsp_if.source rsp
);
   // address into the node ram, node i lives at row i-1
   localparam int AW     = $clog2(POSITIONS);
   // walk index, wide enough for the field and for one step past the top
   localparam int PW     = $clog2(POSITIONS + 1);
   localparam int WALK_W = ((PW > FIELD_W) ? PW : FIELD_W) + 1;
   localparam logic [WALK_W-1:0] POS_MAX  = WALK_W'(POSITIONS);
   localparam logic [AW-1:0]     LAST_ROW = AW'(POSITIONS - 1);

   // sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_INC_RD = 3'd2;
   localparam logic [2:0] S_INC_WR = 3'd3;
   localparam logic [2:0] S_QUERY  = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [WALK_W-1:0]   idx_ff, idx_in;       // current tree index of the walk
   logic [WALK_W-1:0]   low_ff, low_in;       // left-1, start of second prefix
   logic                phase_ff, phase_in;   // query: 0 adds prefix(right)
   logic                pend_ff, pend_in;     // ram read in flight
   logic                pend_sub_ff, pend_sub_in;
   logic [COUNT_W-1:0]  acc_ff, acc_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [AW-1:0]       clr_ff, clr_in;       // sweep row
   logic                clr_reply_ff, clr_reply_in; // sweep came from a command

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // ram port signals
   logic               wr_en, rd_en;
   logic [AW-1:0]      wr_addr, rd_addr;
   logic [COUNT_W-1:0] wr_data, rd_data;

   // shared add/subtract unit
   logic [COUNT_W-1:0] add_a, add_b, add_res;
   logic               add_sub;

   logic [WALK_W-1:0] idx_low, idx_up, idx_down;
   logic [AW-1:0]     idx_row;
   logic              accept;

   assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

   // lowest set bit of the walk index
   assign idx_low  = idx_ff & (~idx_ff + WALK_W'(1));
   assign idx_up   = idx_ff + idx_low;
   assign idx_down = idx_ff - idx_low;
   assign idx_row  = AW'(idx_ff - WALK_W'(1));

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.count  = rsp_count_ff;
   assign rsp.status = rsp_status_ff;

   frc_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (POSITIONS)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      low_in        = low_ff;
      phase_in      = phase_ff;
      pend_in       = pend_ff;
      pend_sub_in   = pend_sub_ff;
      acc_in        = acc_ff;
      stat_in       = stat_ff;
      total_in      = total_ff;
      clr_in        = clr_ff;
      clr_reply_in  = clr_reply_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;

      wr_en   = 1'b0;
      wr_addr = idx_row;
      wr_data = add_res;
      rd_en   = 1'b0;
      rd_addr = idx_row;
      add_a   = acc_ff;
      add_b   = rd_data;
      add_sub = pend_sub_ff;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one row per cycle
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST_ROW) begin
               clr_in   = '0;
               state_in = clr_reply_ff ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               acc_in   = '0;
               stat_in  = ST_DONE;
               state_in = S_DONE;
               unique case (req.command)
                  CMD_INC: begin
                     if (req.position == '0 || WALK_W'(req.position) > POS_MAX) begin
                        stat_in = ST_RANGE;
                     end else if (total_ff == TOTAL_MAX) begin
                        stat_in = ST_FULL;
                     end else begin
                        idx_in   = WALK_W'(req.position);
                        state_in = S_INC_RD;
                     end
                  end
                  CMD_QUERY: begin
                     if (req.left == '0 || WALK_W'(req.right) > POS_MAX) begin
                        stat_in = ST_RANGE;
                     end else if (req.left <= req.right) begin
                        idx_in   = WALK_W'(req.right);
                        low_in   = WALK_W'(req.left) - WALK_W'(1);
                        phase_in = 1'b0;
                        pend_in  = 1'b0;
                        state_in = S_QUERY;
                     end
                  end
                  CMD_CLEAR: begin
                     total_in     = '0;
                     clr_in       = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  default: begin
                     // unused command, plain done beat
                  end
               endcase
            end
         end
         S_INC_RD: begin
            rd_en    = 1'b1;
            state_in = S_INC_WR;
         end
         S_INC_WR: begin
            // node + 1 through the shared adder, then step upward
            add_a   = rd_data;
            add_b   = COUNT_W'(1);
            add_sub = 1'b0;
            wr_en   = 1'b1;
            if (idx_up > POS_MAX) begin
               total_in = total_ff + COUNT_W'(1);
               state_in = S_DONE;
            end else begin
               idx_in   = idx_up;
               state_in = S_INC_RD;
            end
         end
         S_QUERY: begin
            // read of one node overlaps accumulation of the previous one
            if (pend_ff) begin
               acc_in = add_res;
            end
            if (idx_ff != '0) begin
               rd_en       = 1'b1;
               idx_in      = idx_down;
               pend_in     = 1'b1;
               pend_sub_in = phase_ff;
            end else if (!phase_ff) begin
               idx_in   = low_ff;
               phase_in = 1'b1;
               pend_in  = 1'b0;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = acc_ff;
               rsp_status_in = stat_ff;
               clr_reply_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         clr_reply_ff <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_reply_ff <= clr_reply_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      low_ff        <= low_in;
      pend_sub_ff   <= pend_sub_in;
      acc_ff        <= acc_in;
      stat_ff       <= stat_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule
